/* hw/rtl/prr_pkg.sv */
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants
// Fixed-point formats, register indexes and saturation helper used by the
// reprojection residual and Jacobian pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package prr_pkg;

   // Fraction bits of coordinates, residuals and Jacobians.
   localparam int FRAC_BITS = 16;
   // One quotient bit per divider stage.
   localparam int DIV_STEPS = 32;
   // Signed dividend width: a 32-bit value scaled by 2^FRAC_BITS, negated.
   localparam int NUM_W = 33 + FRAC_BITS;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [31:0] word_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANS_X = 3'd0,
      CSR_TRANS_Y = 3'd1,
      CSR_TRANS_Z = 3'd2,
      CSR_QUAT_X  = 3'd3,
      CSR_QUAT_Y  = 3'd4,
      CSR_QUAT_Z  = 3'd5,
      CSR_QUAT_W  = 3'd6
   } csr_index_type;

   localparam word_type QUAT_ONE = 32'sh4000_0000;
   localparam logic signed [NUM_W-1:0] INV_NUM = NUM_W'(1) <<< (2 * FRAC_BITS);

   // Item data that rides alongside the divider lanes.
   typedef struct packed {
      logic                  ok;
      word_type              cz;
      logic [2:0][2:0][31:0] m;
      word_type              obs_u;
      word_type              obs_v;
      word_type              u;
      word_type              v;
      word_type              inv;
   } side_type;

   // One result row; jac[0..5] = tx, ty, tz, rx, ry, rz.
   typedef struct packed {
      logic [5:0][31:0] jac;
      word_type         residual;
      logic             depth_ok;
   } row_type;

   // Saturate a wide signed value to 32 bits.
   function automatic word_type sat32(input logic signed [71:0] v);
      logic signed [71:0] hi_lim;
      logic signed [71:0] lo_lim;
      hi_lim = 72'sh7FFF_FFFF;
      lo_lim = -72'sh8000_0000;
      if (v > hi_lim) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo_lim) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/prr_pose.sv */
// ----------------------------------------------------------------------------
// prr_pose: rigid transform front end
// Builds the rotation matrix from the quaternion, transforms the point and
// forms the rotation part of the Jacobian, over four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_pose (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [2:0][31:0]      in_point,
   input  wire logic [31:0]           in_obs_u,
   input  wire logic [31:0]           in_obs_v,
   input  wire logic [2:0][31:0]      trans,
   input  wire logic [3:0][31:0]      quat,     // x, y, z, w from the lowest up
   output logic                       out_valid,
   output prr_pkg::word_type          out_cx,
   output prr_pkg::word_type          out_cy,
   output prr_pkg::side_type          out_side
);

   localparam logic signed [39:0] ONE40 = 40'sh4000_0000;

   // Q2.30 product scaled back by 30 with a floor shift.
   function automatic logic signed [33:0] mul30(input prr_pkg::word_type a,
                                                input prr_pkg::word_type b);
      logic signed [63:0] p;
      p = a * b;
      return p[63:30];
   endfunction

   logic [3:0] vld_ff;

   logic signed [33:0]  qp_in [9];
   logic signed [33:0]  qp_ff [9];
   prr_pkg::word_type   r_in  [3][3];
   prr_pkg::word_type   r_ff  [3][3];
   logic signed [33:0]  rp_in [3][3][3];
   logic signed [33:0]  rp_ff [3][3][3];
   prr_pkg::word_type   c_in  [3];
   prr_pkg::word_type   c_ff  [3];
   prr_pkg::word_type   m_in  [3][3];
   prr_pkg::word_type   m_ff  [3][3];

   prr_pkg::word_type   p1_ff [3];
   prr_pkg::word_type   p2_ff [3];
   prr_pkg::word_type   t1_ff [3];
   prr_pkg::word_type   t2_ff [3];
   prr_pkg::word_type   t3_ff [3];
   prr_pkg::word_type   ou_ff [4];
   prr_pkg::word_type   ov_ff [4];

   // Stage 1: quaternion component products.
   always_comb begin
      qp_in[0] = mul30($signed(quat[0]), $signed(quat[0]));
      qp_in[1] = mul30($signed(quat[1]), $signed(quat[1]));
      qp_in[2] = mul30($signed(quat[2]), $signed(quat[2]));
      qp_in[3] = mul30($signed(quat[0]), $signed(quat[1]));
      qp_in[4] = mul30($signed(quat[0]), $signed(quat[2]));
      qp_in[5] = mul30($signed(quat[1]), $signed(quat[2]));
      qp_in[6] = mul30($signed(quat[3]), $signed(quat[0]));
      qp_in[7] = mul30($signed(quat[3]), $signed(quat[1]));
      qp_in[8] = mul30($signed(quat[3]), $signed(quat[2]));
   end

   // Stage 2: rotation matrix entries, each saturated.
   always_comb begin
      r_in[0][0] = prr_pkg::sat32(72'(ONE40 - ((40'(qp_ff[1]) + 40'(qp_ff[2])) <<< 1)));
      r_in[0][1] = prr_pkg::sat32(72'((40'(qp_ff[3]) - 40'(qp_ff[8])) <<< 1));
      r_in[0][2] = prr_pkg::sat32(72'((40'(qp_ff[4]) + 40'(qp_ff[7])) <<< 1));
      r_in[1][0] = prr_pkg::sat32(72'((40'(qp_ff[3]) + 40'(qp_ff[8])) <<< 1));
      r_in[1][1] = prr_pkg::sat32(72'(ONE40 - ((40'(qp_ff[0]) + 40'(qp_ff[2])) <<< 1)));
      r_in[1][2] = prr_pkg::sat32(72'((40'(qp_ff[5]) - 40'(qp_ff[6])) <<< 1));
      r_in[2][0] = prr_pkg::sat32(72'((40'(qp_ff[4]) - 40'(qp_ff[7])) <<< 1));
      r_in[2][1] = prr_pkg::sat32(72'((40'(qp_ff[5]) + 40'(qp_ff[6])) <<< 1));
      r_in[2][2] = prr_pkg::sat32(72'(ONE40 - ((40'(qp_ff[0]) + 40'(qp_ff[1])) <<< 1)));
   end

   // Stage 3: every product of a matrix entry and a point coordinate.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               rp_in[i][j][k] = mul30(r_ff[i][j], p2_ff[k]);
            end
         end
      end
   end

   // Stage 4: transformed point and -R*skew(P).
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = prr_pkg::sat32(72'(rp_ff[i][0][0]) + 72'(rp_ff[i][1][1]) +
                                  72'(rp_ff[i][2][2]) + 72'(t3_ff[i]));
         m_in[i][0] = prr_pkg::sat32(72'(rp_ff[i][2][1]) - 72'(rp_ff[i][1][2]));
         m_in[i][1] = prr_pkg::sat32(72'(rp_ff[i][0][2]) - 72'(rp_ff[i][2][0]));
         m_in[i][2] = prr_pkg::sat32(72'(rp_ff[i][1][0]) - 72'(rp_ff[i][0][1]));
      end
   end

   // Valid bits follow the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en) begin
         qp_ff <= qp_in;
         r_ff  <= r_in;
         rp_ff <= rp_in;
         c_ff  <= c_in;
         m_ff  <= m_in;
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= $signed(in_point[i]);
            t1_ff[i] <= $signed(trans[i]);
         end
         p2_ff <= p1_ff;
         t2_ff <= t1_ff;
         t3_ff <= t2_ff;
         ou_ff[0] <= $signed(in_obs_u);
         ov_ff[0] <= $signed(in_obs_v);
         for (int s = 1; s < 4; s++) begin
            ou_ff[s] <= ou_ff[s-1];
            ov_ff[s] <= ov_ff[s-1];
         end
      end
   end

   // Results toward the dividers.
   always_comb begin
      out_valid      = vld_ff[3];
      out_cx         = c_ff[0];
      out_cy         = c_ff[1];
      out_side       = '0;
      out_side.ok    = (c_ff[2] > 0);
      out_side.cz    = c_ff[2];
      out_side.obs_u = ou_ff[3];
      out_side.obs_v = ov_ff[3];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            out_side.m[i][j] = m_ff[i][j];
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/prr_div.sv */
// ----------------------------------------------------------------------------
// prr_div: pipelined three-lane divider
// Divides three signed dividends by one positive divisor, one quotient bit
// per stage, truncating toward zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_div (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    en,
   input  wire logic                                    in_valid,
   input  wire logic [2:0][prr_pkg::NUM_W-1:0]          in_num,
   input  wire logic [31:0]                             in_den,
   input  wire prr_pkg::side_type                       in_side,
   output logic                                         out_valid,
   output logic [2:0][31:0]                             out_quot,
   output prr_pkg::side_type                            out_side
);

   localparam int LAST = prr_pkg::DIV_STEPS;

   logic [LAST:0]           vld_ff;
   logic [2:0][31:0]        rem_in  [LAST+1];
   logic [2:0][31:0]        rem_ff  [LAST+1];
   logic [2:0][31:0]        w_in    [LAST+1];
   logic [2:0][31:0]        w_ff    [LAST+1];
   logic [2:0]              neg_in;
   logic [2:0]              neg_ff  [LAST+1];
   logic [2:0]              ovf_in;
   logic [2:0]              ovf_ff  [LAST+1];
   logic [30:0]             d_in;
   logic [30:0]             d_ff    [LAST+1];
   prr_pkg::side_type       side_ff [LAST+1];

   logic [prr_pkg::NUM_W-1:0] mag;
   logic [32:0]               r2;
   logic [32:0]               diff;
   logic                      ge;

   always_comb begin
      r2   = '0;
      diff = '0;
      ge   = 1'b0;
      // Entry: magnitudes, overflow check on the high part, first remainder.
      d_in = ($signed(in_den) > 0) ? in_den[30:0] : 31'd1;
      for (int l = 0; l < 3; l++) begin
         neg_in[l]    = in_num[l][prr_pkg::NUM_W-1];
         mag          = neg_in[l] ? (~in_num[l] + 1'b1) : in_num[l];
         ovf_in[l]    = 32'(mag[prr_pkg::NUM_W-1:32]) >= {1'b0, d_in};
         rem_in[0][l] = ovf_in[l] ? 32'd0 : 32'(mag[prr_pkg::NUM_W-1:32]);
         w_in[0][l]   = mag[31:0];
      end
      // Restoring steps: one quotient bit per stage and lane.
      for (int k = 1; k <= LAST; k++) begin
         for (int l = 0; l < 3; l++) begin
            r2           = {rem_ff[k-1][l], w_ff[k-1][l][31]};
            diff         = r2 - {2'b00, d_ff[k-1]};
            ge           = (r2 >= {2'b00, d_ff[k-1]});
            rem_in[k][l] = ge ? diff[31:0] : r2[31:0];
            w_in[k][l]   = {w_ff[k-1][l][30:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAST-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         w_ff[0]    <= w_in[0];
         neg_ff[0]  <= neg_in;
         ovf_ff[0]  <= ovf_in;
         d_ff[0]    <= d_in;
         side_ff[0] <= in_side;
         for (int k = 1; k <= LAST; k++) begin
            rem_ff[k]  <= rem_in[k];
            w_ff[k]    <= w_in[k];
            neg_ff[k]  <= neg_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
            d_ff[k]    <= d_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Sign and saturation of the finished quotients.
   always_comb begin
      out_valid = vld_ff[LAST];
      out_side  = side_ff[LAST];
      for (int l = 0; l < 3; l++) begin
         if (neg_ff[LAST][l]) begin
            out_quot[l] = (ovf_ff[LAST][l] || (w_ff[LAST][l] > 32'h8000_0000)) ?
                          32'h8000_0000 : (~w_ff[LAST][l] + 32'd1);
         end else begin
            out_quot[l] = (ovf_ff[LAST][l] || w_ff[LAST][l][31]) ?
                          32'h7FFF_FFFF : w_ff[LAST][l];
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/prr_jac.sv */
// ----------------------------------------------------------------------------
// prr_jac: Jacobian and residual back end
// Multiplies the projection derivatives into the rotation columns and forms
// both result rows, zeroed when the depth is not positive.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_jac (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire prr_pkg::word_type   in_dx,
   input  wire prr_pkg::word_type   in_dy,
   input  wire prr_pkg::side_type   in_side,
   output logic                     out_valid,
   output prr_pkg::row_type         out_row0,
   output prr_pkg::row_type         out_row1
);

   localparam int PW = 64 - prr_pkg::FRAC_BITS;

   // Q.F product scaled back by FRAC_BITS with a floor shift.
   function automatic logic signed [PW-1:0] mulf(input prr_pkg::word_type a,
                                                 input prr_pkg::word_type b);
      logic signed [63:0] p;
      p = a * b;
      return p[63:prr_pkg::FRAC_BITS];
   endfunction

   logic                 vld_ff;
   logic signed [PW-1:0] pa_in [2][3];
   logic signed [PW-1:0] pa_ff [2][3];
   logic signed [PW-1:0] pb_in [2][3];
   logic signed [PW-1:0] pb_ff [2][3];
   prr_pkg::word_type    res_in [2];
   prr_pkg::word_type    res_ff [2];
   prr_pkg::word_type    inv_ff;
   prr_pkg::word_type    dd_ff [2];
   logic                 ok_ff;
   prr_pkg::word_type    dd_in [2];
   prr_pkg::word_type    jr [2][3];

   // Products of the derivatives with the rotation columns, and residuals.
   always_comb begin
      dd_in[0] = in_dx;
      dd_in[1] = in_dy;
      for (int j = 0; j < 3; j++) begin
         pa_in[0][j] = mulf(in_side.inv, $signed(in_side.m[0][j]));
         pa_in[1][j] = mulf(in_side.inv, $signed(in_side.m[1][j]));
         pb_in[0][j] = mulf(in_dx, $signed(in_side.m[2][j]));
         pb_in[1][j] = mulf(in_dy, $signed(in_side.m[2][j]));
      end
      res_in[0] = prr_pkg::sat32(72'(in_side.u) - 72'(in_side.obs_u));
      res_in[1] = prr_pkg::sat32(72'(in_side.v) - 72'(in_side.obs_v));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         res_ff <= res_in;
         inv_ff <= in_side.inv;
         dd_ff  <= dd_in;
         ok_ff  <= in_side.ok;
      end
   end

   // Row assembly; a point behind the camera gives zero rows.
   always_comb begin
      for (int r = 0; r < 2; r++) begin
         for (int j = 0; j < 3; j++) begin
            jr[r][j] = prr_pkg::sat32(72'(pa_ff[r][j]) + 72'(pb_ff[r][j]));
         end
      end
      out_valid = vld_ff;
      out_row0  = '0;
      out_row1  = '0;
      if (ok_ff) begin
         out_row0.depth_ok = 1'b1;
         out_row0.residual = res_ff[0];
         out_row0.jac[0]   = inv_ff;
         out_row0.jac[2]   = dd_ff[0];
         out_row0.jac[3]   = jr[0][0];
         out_row0.jac[4]   = jr[0][1];
         out_row0.jac[5]   = jr[0][2];
         out_row1.depth_ok = 1'b1;
         out_row1.residual = res_ff[1];
         out_row1.jac[1]   = inv_ff;
         out_row1.jac[2]   = dd_ff[1];
         out_row1.jac[3]   = jr[1][0];
         out_row1.jac[4]   = jr[1][1];
         out_row1.jac[5]   = jr[1][2];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/pnp_reprojection_residual_jacobian.sv */
// The first row of a point leaves the output register after passing the pose
// stages, both dividers and the registers between them; the second row comes
// in the next cycle that the first row is taken. The transform and both
// 33-stage dividers take a new point each cycle unless the pipeline stalls;
// the pipeline stalls while the output register holds an untaken second row.
// Synchronous reset empties the pipeline and loads the identity pose.
// ----------------------------------------------------------------------------
// pnp_reprojection_residual_jacobian: top level
// Pose transform, projection by division, and two result rows per point,
// all on one stalling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pnp_reprojection_residual_jacobian (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // point_x, point_y, point_z, obs_u, obs_v from the lowest bits up
   input  wire logic [159:0]                   req_tdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // residual, jac_tx, jac_ty, jac_tz, jac_rx, jac_ry, jac_rz
   output logic [223:0]                        rsp_tdata,
   // row, depth_ok
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic                           csr_we,
   input  wire logic [prr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_wdata
);

   logic [2:0][31:0]  trans_ff;
   logic [3:0][31:0]  quat_ff;

   logic              en;
   logic              pose_valid;
   prr_pkg::word_type pose_cx;
   prr_pkg::word_type pose_cy;
   prr_pkg::side_type pose_side;

   logic [2:0][prr_pkg::NUM_W-1:0] div1_num;
   logic                           div1_valid;
   logic [2:0][31:0]               div1_quot;
   prr_pkg::side_type              div1_side;

   logic                           s5_vld_ff;
   prr_pkg::side_type              s5_side_in;
   prr_pkg::side_type              s5_side_ff;

   logic [2:0][prr_pkg::NUM_W-1:0] div2_num;
   logic                           div2_valid;
   logic [2:0][31:0]               div2_quot;
   prr_pkg::side_type              div2_side;

   logic                           s6_vld_ff;
   prr_pkg::word_type              s6_dx_ff;
   prr_pkg::word_type              s6_dy_ff;
   prr_pkg::side_type              s6_side_ff;

   logic                           jac_valid;
   prr_pkg::row_type               jac_row0;
   prr_pkg::row_type               jac_row1;

   logic                           hold_vld_ff;
   logic                           row_sel_ff;
   logic                           row_sel_in;
   prr_pkg::row_type               row0_ff;
   prr_pkg::row_type               row1_ff;
   prr_pkg::row_type               cur_row;
   logic                           done;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff <= '0;
         quat_ff  <= {prr_pkg::QUAT_ONE, 32'd0, 32'd0, 32'd0};
      end else if (csr_we) begin
         case (prr_pkg::csr_index_type'(csr_index))
            prr_pkg::CSR_TRANS_X: trans_ff[0] <= csr_wdata;
            prr_pkg::CSR_TRANS_Y: trans_ff[1] <= csr_wdata;
            prr_pkg::CSR_TRANS_Z: trans_ff[2] <= csr_wdata;
            prr_pkg::CSR_QUAT_X:  quat_ff[0]  <= csr_wdata;
            prr_pkg::CSR_QUAT_Y:  quat_ff[1]  <= csr_wdata;
            prr_pkg::CSR_QUAT_Z:  quat_ff[2]  <= csr_wdata;
            prr_pkg::CSR_QUAT_W:  quat_ff[3]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register is empty or finishing.
   assign done       = hold_vld_ff && rsp_tready && row_sel_ff;
   assign en         = !hold_vld_ff || done;
   assign req_tready = en;

   prr_pose u_pose (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_point  (req_tdata[95:0]),
      .in_obs_u  (req_tdata[127:96]),
      .in_obs_v  (req_tdata[159:128]),
      .trans     (trans_ff),
      .quat      (quat_ff),
      .out_valid (pose_valid),
      .out_cx    (pose_cx),
      .out_cy    (pose_cy),
      .out_side  (pose_side)
   );

   // Projection and inverse depth.
   always_comb begin
      div1_num[0] = prr_pkg::NUM_W'(pose_cx) <<< prr_pkg::FRAC_BITS;
      div1_num[1] = prr_pkg::NUM_W'(pose_cy) <<< prr_pkg::FRAC_BITS;
      div1_num[2] = prr_pkg::INV_NUM;
   end

   prr_div u_div_proj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pose_valid),
      .in_num    (div1_num),
      .in_den    (pose_side.cz),
      .in_side   (pose_side),
      .out_valid (div1_valid),
      .out_quot  (div1_quot),
      .out_side  (div1_side)
   );

   always_comb begin
      s5_side_in     = div1_side;
      s5_side_in.u   = $signed(div1_quot[0]);
      s5_side_in.v   = $signed(div1_quot[1]);
      s5_side_in.inv = $signed(div1_quot[2]);
   end

   // Derivative of the projection by depth: negated dividends.
   always_comb begin
      div2_num[0] = -(prr_pkg::NUM_W'(s5_side_ff.u) <<< prr_pkg::FRAC_BITS);
      div2_num[1] = -(prr_pkg::NUM_W'(s5_side_ff.v) <<< prr_pkg::FRAC_BITS);
      div2_num[2] = '0;
   end

   prr_div u_div_deriv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s5_vld_ff),
      .in_num    (div2_num),
      .in_den    (s5_side_ff.cz),
      .in_side   (s5_side_ff),
      .out_valid (div2_valid),
      .out_quot  (div2_quot),
      .out_side  (div2_side)
   );

   // Registers between the dividers and around the back end.
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= div1_valid;
         s6_vld_ff <= div2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_side_ff <= s5_side_in;
         s6_side_ff <= div2_side;
         s6_dx_ff   <= $signed(div2_quot[0]);
         s6_dy_ff   <= $signed(div2_quot[1]);
      end
   end

   prr_jac u_jac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_vld_ff),
      .in_dx     (s6_dx_ff),
      .in_dy     (s6_dy_ff),
      .in_side   (s6_side_ff),
      .out_valid (jac_valid),
      .out_row0  (jac_row0),
      .out_row1  (jac_row1)
   );

   // Output register: holds both rows and sends row 0, then row 1.
   always_comb begin
      row_sel_in = row_sel_ff;
      if (en) begin
         row_sel_in = 1'b0;
      end else if (rsp_tready) begin
         row_sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         row_sel_ff  <= 1'b0;
      end else begin
         row_sel_ff <= row_sel_in;
         if (en) begin
            hold_vld_ff <= jac_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         row0_ff <= jac_row0;
         row1_ff <= jac_row1;
      end
   end

   assign cur_row    = row_sel_ff ? row1_ff : row0_ff;
   assign rsp_tvalid = hold_vld_ff;
   assign rsp_tdata  = {cur_row.jac, cur_row.residual};
   assign rsp_tuser  = {cur_row.depth_ok, row_sel_ff};
   assign rsp_tlast  = row_sel_ff;

   // The second row always follows a taken first row.
   a_second_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second row did not follow the first");

   // A point behind the camera gives all-zero payload.
   a_zero_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("nonzero payload with depth not positive");

   // Both rows of one point agree on the depth flag.
   a_rows_agree: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> row0_ff.depth_ok == row1_ff.depth_ok)
      else $error("rows of one point disagree on depth");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result transfer offered right after reset");

endmodule

`default_nettype wire
